// ----- hdl/d8_flow_direction_raster_defines.svh -----
// ----------------------------------------------------------------------------
// D8 flow direction raster - assertion macros
// Clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef D8_FLOW_DIRECTION_RASTER_DEFINES_SVH
`define D8_FLOW_DIRECTION_RASTER_DEFINES_SVH

// Same-cycle implication
`define D8FD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define D8FD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/d8fd_pkg.sv -----
// ----------------------------------------------------------------------------
// d8fd_pkg
// Shared constants, direction codes and types of the D8 flow direction block.
// ----------------------------------------------------------------------------
package d8fd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int ELEV_BITS_DEF = 24;

    // Job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Job layout: nine window samples, result mask, column, row
    localparam int NUM_TAPS = 9;
    localparam int MASK_W   = 4;
    localparam int ROW_W    = 16;
    localparam int COL_W    = 12;
    localparam int FW_W     = 13;
    localparam int DIR_W_BITS = 4;

    // Configuration
    localparam int APB_AW = 3;
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 13'd4096;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 16'd1024;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // D8 codes
    localparam logic [DIR_W_BITS-1:0] DIR_NONE = 4'd0;
    localparam logic [DIR_W_BITS-1:0] DIR_SW   = 4'd1;
    localparam logic [DIR_W_BITS-1:0] DIR_W    = 4'd2;
    localparam logic [DIR_W_BITS-1:0] DIR_NW   = 4'd3;
    localparam logic [DIR_W_BITS-1:0] DIR_N    = 4'd4;
    localparam logic [DIR_W_BITS-1:0] DIR_NE   = 4'd5;
    localparam logic [DIR_W_BITS-1:0] DIR_E    = 4'd6;
    localparam logic [DIR_W_BITS-1:0] DIR_SE   = 4'd7;
    localparam logic [DIR_W_BITS-1:0] DIR_S    = 4'd8;

    // Candidate order: E, W, N, S, NE, NW, SE, SW
    localparam logic [DIR_W_BITS-1:0] DIR_CODE [8] = '{
        DIR_E, DIR_W, DIR_N, DIR_S, DIR_NE, DIR_NW, DIR_SE, DIR_SW
    };

    // 1/sqrt2 in Q0.16; orthogonal weight is a shift by 16
    localparam logic signed [16:0] DIAG_WEIGHT = 17'sd46341;
    localparam int ORTHO_SHIFT = 16;

    typedef struct packed {
        logic            valid;
        logic [Q_CW-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_meta;

endpackage

// ----- hdl/d8fd_queue.sv -----
// ----------------------------------------------------------------------------
// d8fd_queue
// Short register queue of window jobs between the front and the back.
// ----------------------------------------------------------------------------
module d8fd_queue #(
    parameter int WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [WIDTH-1:0]      i_data,
    input  logic                  i_pop,
    output logic [WIDTH-1:0]      o_data,
    output d8fd_pkg::t_q_status   o_status
);

    logic [WIDTH-1:0]               r_mem [d8fd_pkg::Q_DEPTH];
    logic [d8fd_pkg::Q_AW-1:0]      r_wr_ptr;
    logic [d8fd_pkg::Q_AW-1:0]      r_rd_ptr;
    logic [d8fd_pkg::Q_CW-1:0]      r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.valid = (r_count != '0);
    assign o_status.count = r_count;

endmodule

// ----- hdl/d8fd_front.sv -----
// ----------------------------------------------------------------------------
// d8fd_front
// Accepts elevation samples, tracks raster position, keeps the two line
// stores and the window columns, and queues one window job per sample.
// ----------------------------------------------------------------------------
module d8fd_front #(
    parameter int  MAX_WIDTH = d8fd_pkg::MAX_WIDTH_DEF,
    parameter int  ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int JW        = d8fd_pkg::NUM_TAPS * ELEV_BITS + d8fd_pkg::MASK_W
                               + CW + d8fd_pkg::ROW_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [CW-1:0]                  i_last_col,
    input  logic [d8fd_pkg::ROW_W-1:0]     i_last_row,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [ELEV_BITS-1:0]    i_elevation,
    input  d8fd_pkg::t_q_status            i_q_status,
    output logic                           o_push,
    output logic [JW-1:0]                  o_job
);

    localparam int EB     = ELEV_BITS;
    localparam int FILL_W = d8fd_pkg::Q_CW + 1;
    localparam int MASK_LO = d8fd_pkg::NUM_TAPS * EB;
    localparam int CX_LO   = MASK_LO + d8fd_pkg::MASK_W;
    localparam int CY_LO   = CX_LO + CW;

    logic [EB-1:0]                  r_bank0 [MAX_WIDTH];
    logic [EB-1:0]                  r_bank1 [MAX_WIDTH];
    logic [EB-1:0]                  r_rd0;
    logic [EB-1:0]                  r_rd1;

    logic [CW-1:0]                  r_cx;
    logic [d8fd_pkg::ROW_W-1:0]     r_cy;
    logic [CW-1:0]                  n_cx;
    logic [d8fd_pkg::ROW_W-1:0]     n_cy;

    logic                           r_s1_valid;
    logic [EB-1:0]                  r_s1_raw;
    logic [CW-1:0]                  r_s1_cx;
    logic [d8fd_pkg::ROW_W-1:0]     r_s1_cy;
    logic                           r_s1_bank;
    logic [d8fd_pkg::MASK_W-1:0]    r_s1_mask;

    logic [EB-1:0]                  r_win [6];

    logic                           w_accept;
    logic [FILL_W-1:0]              w_fill;
    logic [d8fd_pkg::MASK_W-1:0]    w_mask;
    logic [EB-1:0]                  w_col2 [3];
    logic [JW-1:0]                  w_job;
    logic                           w_pass0;
    logic                           w_pass1;
    logic                           w_left;
    logic                           w_right;

    // Reserve room for the job in flight through the read stage
    assign w_fill     = {1'b0, i_q_status.count} + FILL_W'(r_s1_valid);
    assign o_in_ready = (w_fill < FILL_W'(d8fd_pkg::Q_DEPTH));
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_cx = r_cx + 1'b1;
        n_cy = r_cy;
        if (r_cx == i_last_col) begin
            n_cx = '0;
            n_cy = (r_cy == i_last_row) ? '0 : r_cy + 1'b1;
        end
    end

    // Results owed by this sample: previous row, and the last row itself
    assign w_pass0 = (r_cy != '0);
    assign w_pass1 = (r_cy == i_last_row);
    assign w_left  = (r_cx != '0);
    assign w_right = (r_cx == i_last_col);
    assign w_mask  = {w_pass1 & w_right, w_pass1 & w_left, w_pass0 & w_right, w_pass0 & w_left};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx       <= '0;
            r_cy       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (i_restart) begin
                r_cx <= '0;
                r_cy <= '0;
            end else if (w_accept) begin
                r_cx <= n_cx;
                r_cy <= n_cy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_raw  <= i_elevation;
            r_s1_cx   <= r_cx;
            r_s1_cy   <= r_cy;
            r_s1_bank <= r_cy[0];
            r_s1_mask <= w_mask;
        end
    end

    // Line stores: read old contents, write the new sample into the row's bank
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd0 <= r_bank0[r_cx];
            if (!r_cy[0]) begin
                r_bank0[r_cx] <= i_elevation;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd1 <= r_bank1[r_cx];
            if (r_cy[0]) begin
                r_bank1[r_cx] <= i_elevation;
            end
        end
    end

    assign w_col2[0] = r_s1_bank ? r_rd1 : r_rd0;
    assign w_col2[1] = r_s1_bank ? r_rd0 : r_rd1;
    assign w_col2[2] = r_s1_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r]     <= r_win[3 + r];
                r_win[3 + r] <= w_col2[r];
            end
        end
    end

    always_comb begin
        w_job = '0;
        for (int k = 0; k < 6; k++) begin
            w_job[k*EB +: EB] = r_win[k];
        end
        for (int r = 0; r < 3; r++) begin
            w_job[(6 + r)*EB +: EB] = w_col2[r];
        end
        w_job[MASK_LO +: d8fd_pkg::MASK_W] = r_s1_mask;
        w_job[CX_LO +: CW]                 = r_s1_cx;
        w_job[CY_LO +: d8fd_pkg::ROW_W]    = r_s1_cy;
    end

    assign o_push = r_s1_valid;
    assign o_job  = w_job;

endmodule

// ----- hdl/d8fd_back.sv -----
// ----------------------------------------------------------------------------
// d8fd_back
// Takes window jobs from the queue, issues one pixel per cycle unless stalled
// and finds the steepest descent through drop, weight and compare stages.
// ----------------------------------------------------------------------------
module d8fd_back #(
    parameter int  MAX_WIDTH = d8fd_pkg::MAX_WIDTH_DEF,
    parameter int  ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF,
    localparam int CW        = $clog2(MAX_WIDTH),
    localparam int JW        = d8fd_pkg::NUM_TAPS * ELEV_BITS + d8fd_pkg::MASK_W
                               + CW + d8fd_pkg::ROW_W
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  d8fd_pkg::t_q_status                  i_q_status,
    input  logic [JW-1:0]                        i_job,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [d8fd_pkg::DIR_W_BITS-1:0]      o_direction,
    output logic [d8fd_pkg::COL_W-1:0]           o_column,
    output logic [d8fd_pkg::ROW_W-1:0]           o_row,
    output logic                                 o_last_in_run
);

    localparam int EB      = ELEV_BITS;
    localparam int DW      = EB + 1;
    localparam int WW      = EB + 18;
    localparam int XW      = (CW > d8fd_pkg::COL_W) ? CW : d8fd_pkg::COL_W;
    localparam int MASK_LO = d8fd_pkg::NUM_TAPS * EB;
    localparam int CX_LO   = MASK_LO + d8fd_pkg::MASK_W;
    localparam int CY_LO   = CX_LO + CW;

    logic [JW-1:0]                     r_job;
    logic [d8fd_pkg::MASK_W-1:0]       r_mask;

    logic signed [EB-1:0]              w_s [9];
    logic [CW-1:0]                     w_cx;
    logic [d8fd_pkg::ROW_W-1:0]        w_cy;
    logic [d8fd_pkg::MASK_W-1:0]       w_low;
    logic [d8fd_pkg::MASK_W-1:0]       w_rem;
    logic                              w_right;
    logic                              w_pass1;
    logic                              w_lsel;
    logic                              w_tsel;
    logic signed [EB-1:0]              w_cl [3];
    logic signed [EB-1:0]              w_cm [3];
    logic signed [EB-1:0]              w_cr [3];
    logic signed [EB-1:0]              w_center;
    logic signed [EB-1:0]              w_nb [8];
    logic signed [DW-1:0]              w_d [8];
    logic [CW-1:0]                     w_x;
    logic [XW-1:0]                     w_x_ext;
    d8fd_pkg::t_meta                   w_meta;
    logic                              w_en;

    logic                              r_e1_valid;
    logic signed [DW-1:0]              r_e1_d [8];
    d8fd_pkg::t_meta                   r_e1_meta;

    logic                              r_e2_valid;
    logic signed [WW-1:0]              r_e2_w [8];
    d8fd_pkg::t_meta                   r_e2_meta;

    logic signed [WW-1:0]              w_l1_w [4];
    logic [d8fd_pkg::DIR_W_BITS-1:0]   w_l1_c [4];
    logic signed [WW-1:0]              w_l2_w [2];
    logic [d8fd_pkg::DIR_W_BITS-1:0]   w_l2_c [2];

    logic                              r_e3_valid;
    logic signed [WW-1:0]              r_e3_w [2];
    logic [d8fd_pkg::DIR_W_BITS-1:0]   r_e3_c [2];
    d8fd_pkg::t_meta                   r_e3_meta;

    logic signed [WW-1:0]              w_fin_w;
    logic [d8fd_pkg::DIR_W_BITS-1:0]   w_fin_c;
    logic [d8fd_pkg::DIR_W_BITS-1:0]   w_dir;

    logic                              r_out_valid;
    logic [d8fd_pkg::DIR_W_BITS-1:0]   r_direction;
    d8fd_pkg::t_meta                   r_out_meta;

    // All stages advance together unless the output holds a result
    assign w_en = !r_out_valid || i_out_ready;

    // Issue: lowest pending result of the current job
    assign w_low   = r_mask & (~r_mask + 1'b1);
    assign w_rem   = r_mask & ~w_low;
    assign w_right = w_low[1] | w_low[3];
    assign w_pass1 = w_low[2] | w_low[3];
    assign o_pop   = w_en && i_q_status.valid && (w_rem == '0);

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_s[k] = $signed(r_job[k*EB +: EB]);
        end
    end

    assign w_cx = r_job[CX_LO +: CW];
    assign w_cy = r_job[CY_LO +: d8fd_pkg::ROW_W];

    // Edge clamp: left column and top row fall back onto the pixel itself
    assign w_lsel = w_right || (w_cx == CW'(1));
    assign w_tsel = w_pass1 || (w_cy == 16'd1);

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_cl[r] = w_lsel  ? w_s[3 + r] : w_s[r];
            w_cm[r] = w_right ? w_s[6 + r] : w_s[3 + r];
            w_cr[r] = w_s[6 + r];
        end
        w_center = w_pass1 ? w_cm[2] : w_cm[1];
        w_nb[0]  = w_pass1 ? w_cr[2] : w_cr[1];
        w_nb[1]  = w_pass1 ? w_cl[2] : w_cl[1];
        w_nb[2]  = w_cm[2];
        w_nb[3]  = w_tsel ? w_cm[1] : w_cm[0];
        w_nb[4]  = w_cr[2];
        w_nb[5]  = w_cl[2];
        w_nb[6]  = w_tsel ? w_cr[1] : w_cr[0];
        w_nb[7]  = w_tsel ? w_cl[1] : w_cl[0];
        for (int k = 0; k < 8; k++) begin
            w_d[k] = DW'(w_center) - DW'(w_nb[k]);
        end
    end

    assign w_x         = w_right ? w_cx : w_cx - 1'b1;
    assign w_x_ext     = XW'(w_x);
    assign w_meta.column = w_x_ext[d8fd_pkg::COL_W-1:0];
    assign w_meta.row    = w_pass1 ? w_cy : w_cy - 1'b1;
    assign w_meta.last   = (w_rem == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_e1_valid  <= 1'b0;
            r_e2_valid  <= 1'b0;
            r_e3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_mask      <= o_pop ? i_job[MASK_LO +: d8fd_pkg::MASK_W] : w_rem;
            r_e1_valid  <= (r_mask != '0);
            r_e2_valid  <= r_e1_valid;
            r_e3_valid  <= r_e2_valid;
            r_out_valid <= r_e3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // Drop, weight, pairwise compare, final compare
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 8; k++) begin
                r_e1_d[k] <= w_d[k];
            end
            r_e1_meta <= w_meta;
            for (int k = 0; k < 4; k++) begin
                r_e2_w[k]     <= WW'(r_e1_d[k]) <<< d8fd_pkg::ORTHO_SHIFT;
                r_e2_w[4 + k] <= WW'(r_e1_d[4 + k]) * WW'(d8fd_pkg::DIAG_WEIGHT);
            end
            r_e2_meta <= r_e1_meta;
            for (int q = 0; q < 2; q++) begin
                r_e3_w[q] <= w_l2_w[q];
                r_e3_c[q] <= w_l2_c[q];
            end
            r_e3_meta   <= r_e2_meta;
            r_direction <= w_dir;
            r_out_meta  <= r_e3_meta;
        end
    end

    // Earlier candidate keeps a tie
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            if (r_e2_w[2*p + 1] > r_e2_w[2*p]) begin
                w_l1_w[p] = r_e2_w[2*p + 1];
                w_l1_c[p] = d8fd_pkg::DIR_CODE[2*p + 1];
            end else begin
                w_l1_w[p] = r_e2_w[2*p];
                w_l1_c[p] = d8fd_pkg::DIR_CODE[2*p];
            end
        end
        for (int q = 0; q < 2; q++) begin
            if (w_l1_w[2*q + 1] > w_l1_w[2*q]) begin
                w_l2_w[q] = w_l1_w[2*q + 1];
                w_l2_c[q] = w_l1_c[2*q + 1];
            end else begin
                w_l2_w[q] = w_l1_w[2*q];
                w_l2_c[q] = w_l1_c[2*q];
            end
        end
    end

    assign w_fin_w = (r_e3_w[1] > r_e3_w[0]) ? r_e3_w[1] : r_e3_w[0];
    assign w_fin_c = (r_e3_w[1] > r_e3_w[0]) ? r_e3_c[1] : r_e3_c[0];
    assign w_dir   = (!w_fin_w[WW-1] && (w_fin_w != '0)) ? w_fin_c : d8fd_pkg::DIR_NONE;

    assign o_out_valid   = r_out_valid;
    assign o_direction   = r_direction;
    assign o_column      = r_out_meta.column;
    assign o_row         = r_out_meta.row;
    assign o_last_in_run = r_out_meta.last;

endmodule

// ----- hdl/d8_flow_direction_raster.sv -----
// Throughput: one sample per cycle while each owes at most one result and the
// output is taken; a sample owing more holds the back end while it issues its
// results: 2 at the end of every row but the first, 2 on the last row past its
// first column, 4 for the frame's last.
// Reset: counters, window and valids clear; frame width 4096, height 1024.
// ----------------------------------------------------------------------------
// d8_flow_direction_raster
// D8 steepest-descent direction over a raster elevation stream, with the
// frame size set through an APB register port.
// ----------------------------------------------------------------------------
module d8_flow_direction_raster #(
    parameter int  MAX_WIDTH = d8fd_pkg::MAX_WIDTH_DEF,
    parameter int  ELEV_BITS = d8fd_pkg::ELEV_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [d8fd_pkg::APB_AW-1:0]          paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [ELEV_BITS-1:0]          i_elevation,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [d8fd_pkg::DIR_W_BITS-1:0]      o_direction,
    output logic [d8fd_pkg::COL_W-1:0]           o_column,
    output logic [d8fd_pkg::ROW_W-1:0]           o_row,
    output logic                                 o_last_in_run
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int JW = d8fd_pkg::NUM_TAPS * ELEV_BITS + d8fd_pkg::MASK_W
                        + CW + d8fd_pkg::ROW_W;

    logic [d8fd_pkg::FW_W-1:0]   r_frame_width;
    logic [d8fd_pkg::ROW_W-1:0]  r_frame_height;
    logic                        w_cfg_wr;
    logic [CW-1:0]               w_last_col;
    logic [d8fd_pkg::ROW_W-1:0]  w_last_row;

    logic                        w_push;
    logic [JW-1:0]               w_push_job;
    logic                        w_pop;
    logic [JW-1:0]               w_pop_job;
    d8fd_pkg::t_q_status         w_q_status;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= d8fd_pkg::FRAME_WIDTH_RST;
            r_frame_height <= d8fd_pkg::FRAME_HEIGHT_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                d8fd_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[d8fd_pkg::FW_W-1:0];
                end
                d8fd_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[d8fd_pkg::ROW_W-1:0];
                end
                default: begin
                    r_frame_width <= r_frame_width;
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            d8fd_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, r_frame_width};
            d8fd_pkg::REG_FRAME_HEIGHT: prdata = {16'd0, r_frame_height};
            default:                    prdata = '0;
        endcase
    end

    // Clamp width to 2..MAX_WIDTH and height to at least 2
    always_comb begin
        priority if (r_frame_width < 13'd2) begin
            w_last_col = CW'(1);
        end else if ({19'd0, r_frame_width} > 32'(MAX_WIDTH)) begin
            w_last_col = CW'(MAX_WIDTH - 1);
        end else begin
            w_last_col = CW'(r_frame_width - 13'd1);
        end
    end

    assign w_last_row = (r_frame_height < 16'd2) ? 16'd1 : r_frame_height - 16'd1;

    d8fd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .ELEV_BITS (ELEV_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (w_cfg_wr),
        .i_last_col  (w_last_col),
        .i_last_row  (w_last_row),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_elevation (i_elevation),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    d8fd_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_job),
        .i_pop    (w_pop),
        .o_data   (w_pop_job),
        .o_status (w_q_status)
    );

    d8fd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .ELEV_BITS (ELEV_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_job         (w_pop_job),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_direction   (o_direction),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_last_in_run (o_last_in_run)
    );

endmodule

// ----- hdl/d8fd_checker.sv -----
// ----------------------------------------------------------------------------
// d8fd_checker
// Port-level checks on the result stream of the D8 flow direction block.
// ----------------------------------------------------------------------------
`include "d8_flow_direction_raster_defines.svh"

module d8fd_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    input  logic [d8fd_pkg::DIR_W_BITS-1:0]      o_direction,
    input  logic [d8fd_pkg::COL_W-1:0]           o_column,
    input  logic [d8fd_pkg::ROW_W-1:0]           o_row,
    input  logic                                 o_last_in_run
);

    `D8FD_ASSERT_NOW(a_dir_code, o_out_valid, o_direction <= d8fd_pkg::DIR_S, "direction code above 8")

    `D8FD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_direction) && $stable(o_column) && $stable(o_row) && $stable(o_last_in_run), "stalled result changed")

    `D8FD_ASSERT_NEXT(a_run_burst, o_out_valid && i_out_ready && !o_last_in_run, o_out_valid, "gap inside a run of results")

    `D8FD_ASSERT_NEXT(a_run_row, o_out_valid && i_out_ready && !o_last_in_run, (o_row == $past(o_row)) || (o_row == $past(o_row) + 16'd1), "row jump inside a run")

endmodule

bind d8_flow_direction_raster d8fd_checker u_d8fd_checker (.*);

// ----- tb/sv/d8_flow_direction_raster_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D8 flow direction raster testbench
// Streams elevation rasters through the block under several frame sizes,
// predicts every D8 result from a line-buffered window of its own, and checks
// each result in order. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
package d8_flow_check_pkg;
    import d8fd_pkg::*;

    localparam int     LINE_SLOTS   = MAX_WIDTH_DEF;
    localparam int     ELEV_W       = ELEV_BITS_DEF;
    localparam longint ORTHO_Q16    = 65536;
    localparam longint DIAG_Q16     = 46341;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DIR_W_BITS-1:0] direction;
        logic [COL_W-1:0]      column;
        logic [ROW_W-1:0]      row;
        logic                  last;
    } flow_result_t;

    class flow_scoreboard;
        logic signed [ELEV_W-1:0] line_mem [2*LINE_SLOTS];
        logic signed [ELEV_W-1:0] window_mem [6];
        logic signed [ELEV_W-1:0] taps [3][3];
        logic [FW_W-1:0]          width_reg;
        logic [ROW_W-1:0]         height_reg;
        int unsigned              col_count;
        int unsigned              row_count;
        flow_result_t             expected_dirs [$];
        int                       errors;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (window_mem[i]) window_mem[i] = '0;
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            col_count  = 0;
            row_count  = 0;
            errors     = 0;
        endfunction

        function void write_register(logic idx, logic [31:0] data);
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = data[FW_W-1:0];
            end else begin
                height_reg = data[ROW_W-1:0];
            end
            col_count = 0;
            row_count = 0;
        endfunction

        function logic [DIR_W_BITS-1:0] steepest_code(int lf, int md, int rt,
                                                      int tp, int mr, int bt);
            int                    nc [8];
            int                    nr [8];
            longint                centre;
            longint                drop;
            longint                weight;
            longint                best;
            logic [DIR_W_BITS-1:0] code;
            nc = '{rt, lf, md, md, rt, lf, rt, lf};
            nr = '{mr, mr, bt, tp, bt, bt, tp, tp};
            centre = taps[md][mr];
            best = 0;
            code = DIR_NONE;
            for (int k = 0; k < 8; k++) begin
                drop = centre - taps[nc[k]][nr[k]];
                weight = drop * ((k < 4) ? ORTHO_Q16 : DIAG_Q16);
                if (weight > best) begin
                    best = weight;
                    code = DIR_CODE[k];
                end
            end
            return code;
        endfunction

        function void note_elevation(logic [ELEV_W-1:0] sample);
            int unsigned  w;
            int unsigned  h;
            int unsigned  cx;
            int unsigned  cy;
            int unsigned  bank;
            int unsigned  y;
            int           tp;
            int           mr;
            int           bt;
            int           n;
            bit           active;
            flow_result_t batch [4];
            w = (width_reg < 2) ? 2 : ((width_reg > LINE_SLOTS) ? LINE_SLOTS : width_reg);
            h = (height_reg < 2) ? 2 : height_reg;
            cx = (col_count >= w) ? w - 1 : col_count;
            cy = row_count;
            bank = cy & 1;
            for (int r = 0; r < 3; r++) begin
                taps[0][r] = window_mem[r];
                taps[1][r] = window_mem[3+r];
            end
            taps[2][0] = line_mem[bank*LINE_SLOTS + cx];
            taps[2][1] = line_mem[(bank^1)*LINE_SLOTS + cx];
            taps[2][2] = sample;
            line_mem[bank*LINE_SLOTS + cx] = sample;

            n = 0;
            for (int pass = 0; pass < 2; pass++) begin
                active = 1'b0;
                if (pass == 0 && cy >= 1) begin
                    active = 1'b1;
                    y = cy - 1;
                    tp = (y == 0) ? 1 : 0;
                    mr = 1;
                    bt = 2;
                end else if (pass == 1 && cy == h - 1) begin
                    active = 1'b1;
                    y = cy;
                    tp = 1;
                    mr = 2;
                    bt = 2;
                end
                if (active && cx >= 1) begin
                    batch[n].direction = steepest_code((cx == 1) ? 1 : 0, 1, 2, tp, mr, bt);
                    batch[n].column    = COL_W'(cx - 1);
                    batch[n].row       = ROW_W'(y);
                    batch[n].last      = 1'b0;
                    n++;
                end
                if (active && cx == w - 1) begin
                    batch[n].direction = steepest_code(1, 2, 2, tp, mr, bt);
                    batch[n].column    = COL_W'(cx);
                    batch[n].row       = ROW_W'(y);
                    batch[n].last      = 1'b0;
                    n++;
                end
            end
            if (n > 0) batch[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) expected_dirs.push_back(batch[i]);

            for (int r = 0; r < 3; r++) begin
                window_mem[r]   = window_mem[3+r];
                window_mem[3+r] = taps[2][r];
            end
            cx++;
            if (cx >= w) begin
                cx = 0;
                cy++;
                if (cy >= h) cy = 0;
            end
            col_count = cx;
            row_count = cy;
        endfunction

        function void check_direction(flow_result_t got);
            flow_result_t want;
            if (expected_dirs.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR: unexpected result dir=%0d col=%0d row=%0d last=%0b",
                             got.direction, got.column, got.row, got.last);
            end else begin
                want = expected_dirs.pop_front();
                if (got.direction !== want.direction || got.column !== want.column ||
                    got.row !== want.row || got.last !== want.last) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display({"ERROR: expected dir=%0d col=%0d row=%0d last=%0b, ",
                                  "got dir=%0d col=%0d row=%0d last=%0b"},
                                 want.direction, want.column, want.row, want.last,
                                 got.direction, got.column, got.row, got.last);
                end
            end
        endfunction

        function int pending();
            return expected_dirs.size();
        endfunction

        function void close_out();
            if (expected_dirs.size() != 0) begin
                errors += expected_dirs.size();
                $display("ERROR: %0d results never arrived", expected_dirs.size());
            end
        endfunction
    endclass
endpackage

module d8_flow_direction_raster_tb;
    import d8fd_pkg::*;
    import d8_flow_check_pkg::*;

    localparam int                RANDOM_ITEMS     = 360;
    localparam int                SETTLE_CYCLES    = 24;
    localparam int                LONG_HOLD_CYCLES = 200;
    localparam int                CYCLE_LIMIT      = 2_000_000;
    localparam logic [ELEV_W-1:0] ELEV_MAX         = 24'h7FFFFF;
    localparam logic [ELEV_W-1:0] ELEV_MIN         = 24'h800000;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     psel       = 1'b0;
    logic                     penable    = 1'b0;
    logic                     pwrite     = 1'b0;
    logic [APB_AW-1:0]        paddr      = '0;
    logic [31:0]              pwdata     = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic signed [ELEV_W-1:0] elevation  = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic [DIR_W_BITS-1:0]    out_direction;
    logic [COL_W-1:0]         out_column;
    logic [ROW_W-1:0]         out_row;
    logic                     out_last;

    bit                       idle_on      = 1'b1;
    int                       hold_tickets = 0;
    int                       cycle_count  = 0;
    flow_scoreboard           scoreboard   = new();

    d8_flow_direction_raster DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_elevation   (elevation),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_direction   (out_direction),
        .o_column      (out_column),
        .o_row         (out_row),
        .o_last_in_run (out_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: cycle limit reached");
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid === 1'b1 && out_ready)
            scoreboard.check_direction(
                flow_result_t'({out_direction, out_column, out_row, out_last}));
    end

    initial begin : receiver
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left  = 0;
        hold_seen  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_tickets != hold_seen) begin
                hold_seen = hold_tickets;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic apb_write(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        scoreboard.write_register(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_frame(input logic [31:0] width_raw, input logic [31:0] height_raw);
        apb_write(REG_FRAME_WIDTH, width_raw);
        apb_write(REG_FRAME_HEIGHT, height_raw);
    endtask

    task automatic push_elevation(input logic [ELEV_W-1:0] sample);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        elevation <= sample;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        scoreboard.note_elevation(sample);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [ELEV_W-1:0] terrain_sample(input int base);
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return ELEV_MAX;
        if (pick == 1) return ELEV_MIN;
        if (pick < 4) return ELEV_W'($urandom);
        return ELEV_W'(base + int'($urandom_range(0, 24)) - 12);
    endfunction

    task automatic send_terrain(input int count, input int base);
        repeat (count) push_elevation(terrain_sample(base));
    endtask

    initial begin : stimulus
        int          cone [9];
        int          pit [9];
        logic [31:0] width_raw;
        logic [31:0] height_raw;
        int          w_eff;
        int          h_eff;
        int          n_items;
        int          base;
        int          random_sent;
        int          phase;
        cone = '{40, 60, 40, 60, 100, 60, 40, 60, 40};
        pit  = '{0, 0, 0, 0, -50, 0, 0, 0, 0};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes side by side
        set_frame(32'd2, 32'd2);
        push_elevation(ELEV_MAX);
        push_elevation(ELEV_MIN);
        push_elevation(ELEV_MIN);
        push_elevation(ELEV_MAX);
        drain_results();

        // clamp both registers up to two, flat plateau
        set_frame(32'd0, 32'd1);
        repeat (4) push_elevation(24'd5);
        drain_results();

        // diagonal beats orthogonal after scaling; then a pit
        set_frame(32'd3, 32'd3);
        foreach (cone[i]) push_elevation(ELEV_W'(cone[i]));
        foreach (pit[i]) push_elevation(ELEV_W'(pit[i]));
        drain_results();

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       width_raw = $urandom_range(0, 1);
                1:       width_raw = ($urandom & 32'hFFFF_E000) | $urandom_range(2, 9);
                default: width_raw = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 5))
                0:       height_raw = $urandom_range(0, 1);
                1:       height_raw = ($urandom & 32'hFFFF_0000) | $urandom_range(2, 5);
                default: height_raw = $urandom_range(2, 6);
            endcase
            w_eff = (width_raw[FW_W-1:0] < 2) ? 2 : int'(width_raw[FW_W-1:0]);
            h_eff = (height_raw[ROW_W-1:0] < 2) ? 2 : int'(height_raw[ROW_W-1:0]);
            n_items = w_eff * h_eff * $urandom_range(1, 3);
            if ($urandom_range(0, 2) == 0) n_items += $urandom_range(1, w_eff * h_eff - 1);
            if (phase == 1) n_items += 64;
            idle_on = ($urandom_range(0, 4) != 0) || phase == 1;
            base = int'($urandom_range(0, 2_000_000)) - 1_000_000;
            set_frame(width_raw, height_raw);
            if (phase == 1) hold_tickets++;
            if (phase == 2) begin
                send_terrain(n_items / 2, base);
                drain_results();
                send_terrain(n_items - n_items / 2, base);
            end else begin
                send_terrain(n_items, base);
            end
            drain_results();
            random_sent += n_items;
            phase++;
        end

        // widest frame: a partial first row only, then a clamped width
        idle_on = 1'b1;
        set_frame(32'd4096, 32'd2);
        send_terrain(6, 0);
        drain_results();
        set_frame(32'h0000_1FFF, 32'h0000_FFFF);
        send_terrain(6, int'($urandom_range(0, 2_000_000)) - 1_000_000);
        drain_results();

        idle_on = 1'b0;
        set_frame(32'd6, 32'd4);
        send_terrain(48, int'($urandom_range(0, 2_000_000)) - 1_000_000);
        drain_results();

        scoreboard.close_out();
        if (scoreboard.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
